// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the suboscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define AST_DIS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Property checked on every clock edge, reset included.
`define AST_ALL(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AST_DIS(lbl, clk, rst_n, prop)
`define AST_ALL(lbl, clk, prop)
`endif
`endif

// ===== rtl/pso_pkg.sv =====
// Shared types and constants of the probabilistic suboscillator.
package pso_pkg;

	// Register and field widths
	localparam int SUB_W   = 9;
	localparam int PROB_W  = 17;
	localparam int SR_W    = 18;
	localparam int DRAW_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int FREQ_W  = 18;
	localparam int CFG_W   = 18;
	localparam int CFG_IDX_W = 2;

	// Parameter defaults
	localparam int PHASE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 24;
	localparam int MAX_STEPS_DEF  = 256;

	// Register reset values
	localparam logic [SUB_W-1:0]  SUB_RST  = 9'd2;
	localparam logic [PROB_W-1:0] PROB_RST = 17'd65536;
	localparam logic [SR_W-1:0]   SR_RST   = 18'd48000;

	// Level in Q15: fraction bits and saturation limits
	localparam int LVL_FRAC = 15;
	localparam logic [LEVEL_W-1:0] LVL_MAX = 16'h7FFF;
	localparam logic [LEVEL_W-1:0] LVL_MIN = 16'h8000;

	// Output stream packing
	localparam int OUT_TDATA_W = ((LEVEL_W + FREQ_W + 1 + 7) / 8) * 8;

	// Divider step counter
	localparam int DIV_STEP_W = 5;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUBDIV = 2'd0,
		CFG_PROB   = 2'd1,
		CFG_RATE   = 2'd2
	} cfg_idx_t;

	// Request to the serial divider
	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_ctl_t;

endpackage

// ===== rtl/probabilistic_suboscillator_unit.sv =====
// Top level of the probabilistic suboscillator.
//
// Input stream s_*: one request per sample carrying a phasor phase and a
// random draw. Output stream m_*: one result per request with the stepped
// level (Q15), the held frequency in hertz and a flag for an index step.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 step
// count, 1 step probability, 2 sample rate); other indexes are ignored.
//
// Work runs through one bit-serial divider, one bit per cycle. A sample
// without a step passes through a level set-up state and the 15-bit level
// division, which is skipped when the level saturates. A step first adds
// the index modulo pass of log2(MAX_STEPS)+1 bits; a return of the index to
// zero then adds the 18-bit frequency division.
// One request is in work at a time; s_tready is high only while idle, so the
// next request can be taken from the cycle after the result is loaded.
// A finished result waits in the output register; the next request is
// accepted meanwhile, and its result waits in the block while m_tready
// stays low. Reset clears the state and the registers to their defaults.
`include "assert_macros.svh"
module probabilistic_suboscillator_unit #(
	parameter int PHASE_BITS = pso_pkg::PHASE_BITS_DEF,
	parameter int COUNT_BITS = pso_pkg::COUNT_BITS_DEF,
	parameter int MAX_STEPS  = pso_pkg::MAX_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// phase_in [PHASE_BITS-1:0], random_draw [PHASE_BITS+15:PHASE_BITS], zero fill
	input  logic [((PHASE_BITS + pso_pkg::DRAW_W + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// level [15:0], frequency [33:16], stepped [34], zero fill
	output logic [pso_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_we,
	input  logic [pso_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pso_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int S_W    = pso_pkg::SUB_W;
	localparam int IDX_W  = $clog2(MAX_STEPS);
	localparam int SMAX_I = (MAX_STEPS < (1 << S_W) - 1) ? MAX_STEPS : (1 << S_W) - 1;
	localparam int NUM_A  = (pso_pkg::SR_W > IDX_W + 1) ? pso_pkg::SR_W : IDX_W + 1;
	localparam int NUM_W  = (NUM_A > pso_pkg::LVL_FRAC) ? NUM_A : pso_pkg::LVL_FRAC;
	localparam int DEN_W  = (COUNT_BITS > S_W) ? COUNT_BITS : S_W;
	localparam int LW     = ((IDX_W + 1 > S_W) ? IDX_W + 1 : S_W) + 1;
	localparam int OUT_PAD = pso_pkg::OUT_TDATA_W - pso_pkg::LEVEL_W - pso_pkg::FREQ_W - 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MOD  = 6'b000010,
		ST_FRQ  = 6'b000100,
		ST_LSET = 6'b001000,
		ST_LVL  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [pso_pkg::SUB_W-1:0]   sub_q;
	logic [pso_pkg::PROB_W-1:0]  prob_q;
	logic [pso_pkg::SR_W-1:0]    rate_q;
	logic [PHASE_BITS-1:0]       prev_q;
	logic [IDX_W-1:0]            idx_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic [pso_pkg::FREQ_W-1:0]  freq_q;
	logic [S_W-1:0]              s_eff_q;
	logic                        stepped_q;
	logic                        neg_q;
	logic [pso_pkg::LEVEL_W-1:0] level_q;
	logic                        m_tvalid_q;
	logic [pso_pkg::LEVEL_W-1:0] m_level_q;
	logic [pso_pkg::FREQ_W-1:0]  m_freq_q;
	logic                        m_step_q;

	logic [PHASE_BITS-1:0]       phase_w;
	logic [pso_pkg::DRAW_W-1:0]  draw_w;
	logic                        accept;
	logic                        do_step;
	logic [S_W-1:0]              s_clamp;
	logic [IDX_W:0]              idx_p1;
	logic [IDX_W-1:0]            idx_new;
	logic [S_W-1:0]              d_w;
	logic [LW-1:0]               diff_w;
	logic [LW-1:0]               mag_w;
	logic                        neg_w;
	logic                        sat_w;
	logic [pso_pkg::LVL_FRAC:0]  q_w;
	logic                        out_load;

	pso_pkg::div_ctl_t div_ctl;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [DEN_W-1:0]  div_rinit;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [DEN_W-1:0]  div_rem;

	assign phase_w = s_tdata[PHASE_BITS-1:0];
	assign draw_w  = s_tdata[PHASE_BITS +: pso_pkg::DRAW_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// draw is at most 65535, so a probability of one (65536) or above always steps on a phase wrap
	assign do_step  = (phase_w < prev_q) && ({1'b0, draw_w} < prob_q);
	assign idx_p1   = {1'b0, idx_q} + 1'b1;
	assign idx_new  = div_rem[IDX_W-1:0];

	// step count clamped to [2, MAX_STEPS], and to 511 at most
	always_comb begin
		if (sub_q < S_W'(2)) begin
			s_clamp = S_W'(2);
		end else if (sub_q > S_W'(SMAX_I)) begin
			s_clamp = S_W'(SMAX_I);
		end else begin
			s_clamp = sub_q;
		end
	end

	// level numerator 2*idx-(S-1), split into sign and magnitude
	assign d_w    = s_eff_q - 1'b1;
	assign diff_w = LW'({idx_q, 1'b0}) - LW'(d_w);
	assign neg_w  = diff_w[LW-1];
	assign mag_w  = neg_w ? (~diff_w + 1'b1) : diff_w;
	assign sat_w  = (mag_w >= LW'(d_w));
	assign q_w    = {1'b0, div_quo[pso_pkg::LVL_FRAC-1:0]};

	// divider requests: index modulo, frequency, level fraction
	always_comb begin
		div_ctl   = '0;
		div_num   = '0;
		div_den   = '0;
		div_rinit = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && do_step) begin
					div_ctl.start = 1'b1;
					div_ctl.steps = pso_pkg::DIV_STEP_W'(IDX_W + 1);
					div_num = NUM_W'(idx_p1) << (NUM_W - IDX_W - 1);
					div_den = DEN_W'(s_clamp);
				end
			end
			ST_MOD: begin
				if (div_done && idx_new == '0) begin
					div_ctl.start = 1'b1;
					div_ctl.steps = pso_pkg::DIV_STEP_W'(pso_pkg::SR_W);
					div_num = NUM_W'(rate_q) << (NUM_W - pso_pkg::SR_W);
					div_den = (count_q == '0) ? DEN_W'(1) : DEN_W'(count_q);
				end
			end
			ST_LSET: begin
				if (!sat_w) begin
					div_ctl.start = 1'b1;
					div_ctl.steps = pso_pkg::DIV_STEP_W'(pso_pkg::LVL_FRAC);
					div_den   = DEN_W'(d_w);
					div_rinit = DEN_W'(mag_w);
				end
			end
			default: begin
			end
		endcase
	end

	pso_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.num(div_num),
		.den(div_den),
		.rem_init(div_rinit),
		.done(div_done),
		.quo(div_quo),
		.rem(div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= pso_pkg::SUB_RST;
			prob_q <= pso_pkg::PROB_RST;
			rate_q <= pso_pkg::SR_RST;
		end else if (cfg_we) begin
			case (pso_pkg::cfg_idx_t'(cfg_index))
				pso_pkg::CFG_SUBDIV: sub_q  <= cfg_wdata[pso_pkg::SUB_W-1:0];
				pso_pkg::CFG_PROB:   prob_q <= cfg_wdata[pso_pkg::PROB_W-1:0];
				pso_pkg::CFG_RATE:   rate_q <= cfg_wdata[pso_pkg::SR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// sequencer and oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_q    <= '0;
			idx_q     <= IDX_W'(1);
			count_q   <= '0;
			freq_q    <= '0;
			stepped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q    <= phase_w;
						stepped_q <= do_step;
						state_q   <= do_step ? ST_MOD : ST_LSET;
					end
				end
				ST_MOD: begin
					if (div_done) begin
						idx_q   <= idx_new;
						state_q <= (idx_new == '0) ? ST_FRQ : ST_LSET;
					end
				end
				ST_FRQ: begin
					if (div_done) begin
						freq_q  <= div_quo[pso_pkg::FREQ_W-1:0];
						count_q <= '0;
						state_q <= ST_LSET;
					end
				end
				ST_LSET: begin
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= sat_w ? ST_OUT : ST_LVL;
				end
				ST_LVL: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-request working values
	always_ff @(posedge clk) begin
		if (accept) begin
			s_eff_q <= s_clamp;
		end
		if (state_q == ST_LSET) begin
			neg_q <= neg_w;
			if (sat_w) begin
				level_q <= neg_w ? pso_pkg::LVL_MIN : pso_pkg::LVL_MAX;
			end
		end
		if (state_q == ST_LVL && div_done) begin
			level_q <= neg_q ? pso_pkg::LEVEL_W'(~q_w + 1'b1) : pso_pkg::LEVEL_W'(q_w);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_level_q <= level_q;
			m_freq_q  <= freq_q;
			m_step_q  <= stepped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, m_step_q, m_freq_q, m_level_q};

	`AST_DIS(a_idx_range, clk, arst_n, (32'(idx_q) < 32'(MAX_STEPS)))
	`AST_DIS(a_freq_restart, clk, arst_n, !$stable(freq_q) |-> (count_q == '0))
	`AST_DIS(a_div_owner, clk, arst_n,
		div_done |-> (state_q == ST_MOD || state_q == ST_FRQ || state_q == ST_LVL))

endmodule

// ===== rtl/pso_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module pso_div #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pso_pkg::div_ctl_t  ctl,
	input  logic [NUM_W-1:0]   num,      // dividend, taken from the top bit down
	input  logic [DEN_W-1:0]   den,
	input  logic [DEN_W-1:0]   rem_init, // partial remainder at start, below den
	output logic               done,
	output logic [NUM_W-1:0]   quo,      // quotient in the low ctl.steps bits
	output logic [DEN_W-1:0]   rem
);

	logic [pso_pkg::DIV_STEP_W-1:0] cnt_q;
	logic                           done_q;
	logic [NUM_W-1:0]               num_q;
	logic [DEN_W-1:0]               den_q;
	logic [DEN_W-1:0]               rem_q;
	logic [DEN_W:0]                 trial;
	logic [DEN_W:0]                 diff;
	logic                           ge;
	logic                           busy;

	assign busy  = (cnt_q != '0);
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == pso_pkg::DIV_STEP_W'(1));
			if (ctl.start) begin
				cnt_q <= ctl.steps;
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= rem_init;
		end else if (busy) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

	`AST_DIS(a_rem_below_den, clk, arst_n, busy |-> (rem_q < den_q))
	`AST_DIS(a_done_idle, clk, arst_n, done_q |-> !busy)
	`AST_DIS(a_no_restart, clk, arst_n, ctl.start |-> !busy)

endmodule
